// ===== sv/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the priority task store.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int ENT_W  = ID_W + PRI_W;
  localparam int STAT_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_PUSHED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SERVED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

// ===== sv/priority_task_store.sv =====
`timescale 1ns / 1ps
// Timing: a push, and a pop on an empty store, answer in the cycle after transfer.
// A pop with tasks stored scans every stored slot, then, unless the chosen slot is
// the last one, shifts the later entries down over the read port before answering.
// Throughput: pushes one per cycle when idle; pops bound by the single read port.
// Reset: synchronous, clears task count and control; entry memory is not cleared.
// Results carry a one-cycle strobe and cannot be stalled.
// ----------------------------------------------------------------------------
// priority_task_store
// Ordered task store in one synchronous memory; pop scans for the best
// priority and shifts later entries down over the same read port.
// ----------------------------------------------------------------------------
module priority_task_store #(
  parameter int CAPACITY = pts_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic [pts_pkg::ID_W-1:0]  in_task_id,
  input  logic [pts_pkg::PRI_W-1:0] in_task_priority,
  output logic                      out_valid,
  output logic [pts_pkg::STAT_W-1:0] out_status,
  output logic [pts_pkg::ID_W-1:0]  out_served_id,
  output logic [pts_pkg::PRI_W-1:0] out_served_priority
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = pts_pkg::ID_W;
  localparam int PW = pts_pkg::PRI_W;

  logic [pts_pkg::ENT_W-1:0] mem [CAPACITY];
  logic [pts_pkg::ENT_W-1:0] rd_data_r;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [pts_pkg::ENT_W-1:0] wr_data;

  pts_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [IW-1:0] best_id_r, best_id_nxt;
  logic [PW-1:0] best_pri_r, best_pri_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [pts_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IW-1:0] out_id_r, out_id_nxt;
  logic [PW-1:0] out_pri_r, out_pri_nxt;

  logic          accept;
  logic          full;
  logic          issue;
  logic          at_last;
  logic          take;
  logic [IW-1:0] cand_id;
  logic [PW-1:0] cand_pri;

  assign accept   = start && (state_r == pts_pkg::ST_IDLE);
  assign full     = (count_r == CW'(CAPACITY));
  assign issue    = (issue_idx_r <= CW'(last_r));
  assign at_last  = rd_vld_r && (chk_idx_r == CW'(last_r));
  assign cand_id  = rd_data_r[pts_pkg::ENT_W-1:PW];
  assign cand_pri = rd_data_r[PW-1:0];
  assign take     = rd_vld_r && ((chk_idx_r == '0) || (cand_pri > best_pri_r) ||
                    ((cand_pri == best_pri_r) && (chk_idx_r == CW'(last_r))));

  always_comb begin
    best_idx_nxt = best_idx_r;
    best_id_nxt  = best_id_r;
    best_pri_nxt = best_pri_r;
    if (state_r == pts_pkg::ST_SCAN && take) begin
      best_idx_nxt = chk_idx_r[AW-1:0];
      best_id_nxt  = cand_id;
      best_pri_nxt = cand_pri;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (accept && in_opcode == pts_pkg::OP_POP && count_r != '0) begin
          state_nxt = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (at_last) begin
          state_nxt = (best_idx_nxt == last_r) ? pts_pkg::ST_IDLE : pts_pkg::ST_SHIFT;
        end
      end
      pts_pkg::ST_SHIFT: begin
        if (at_last) begin
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rd_addr        = issue_idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = AW'(chk_idx_r - 1'b1);
    wr_data        = rd_data_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    issue_idx_nxt  = issue_idx_r;
    chk_idx_nxt    = chk_idx_r;
    rd_vld_nxt     = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = '0;
    out_pri_nxt    = '0;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (in_opcode == pts_pkg::OP_PUSH) begin
            if (full) begin
              out_status_nxt = pts_pkg::STAT_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = count_r[AW-1:0];
              wr_data        = {in_task_id, in_task_priority};
              count_nxt      = count_r + 1'b1;
              out_status_nxt = pts_pkg::STAT_PUSHED;
            end
          end else if (count_r == '0) begin
            out_status_nxt = pts_pkg::STAT_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            last_nxt      = AW'(count_r - 1'b1);
            rd_vld_nxt    = 1'b1;
            chk_idx_nxt   = '0;
            issue_idx_nxt = CW'(1);
          end
        end
      end
      pts_pkg::ST_SCAN: begin
        rd_vld_nxt = issue;
        chk_idx_nxt = issue_idx_r;
        if (issue) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
        if (at_last) begin
          rd_vld_nxt    = 1'b0;
          issue_idx_nxt = CW'(best_idx_nxt) + 1'b1;
          if (best_idx_nxt == last_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pts_pkg::STAT_SERVED;
            out_id_nxt     = best_id_nxt;
            out_pri_nxt    = best_pri_nxt;
            count_nxt      = CW'(last_r);
          end
        end
      end
      pts_pkg::ST_SHIFT: begin
        rd_vld_nxt  = issue;
        chk_idx_nxt = issue_idx_r;
        if (issue) begin
          issue_idx_nxt = issue_idx_r + 1'b1;
        end
        wr_en = rd_vld_r;
        if (at_last) begin
          rd_vld_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = pts_pkg::STAT_SERVED;
          out_id_nxt     = best_id_r;
          out_pri_nxt    = best_pri_r;
          count_nxt      = CW'(last_r);
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pts_pkg::ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    issue_idx_r  <= issue_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_id_r    <= best_id_nxt;
    best_pri_r   <= best_pri_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_pri_r    <= out_pri_nxt;
  end

  assign busy                = (state_r != pts_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_id       = out_id_r;
  assign out_served_priority = out_pri_r;

endmodule

// ===== sv/pts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_assert
// Port-level checks for the priority task store, bound into every store instance.
// ----------------------------------------------------------------------------
module pts_assert (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_opcode,
  input logic                       out_valid,
  input logic [pts_pkg::STAT_W-1:0] out_status,
  input logic [pts_pkg::ID_W-1:0]   out_served_id,
  input logic [pts_pkg::PRI_W-1:0]  out_served_priority
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("strobe or busy after reset");

  a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == pts_pkg::OP_PUSH |=>
      out_valid && (out_status == pts_pkg::STAT_PUSHED ||
                    out_status == pts_pkg::STAT_FULL))
    else $error("push transfer without push result");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pts_pkg::STAT_SERVED |->
      out_served_id == '0 && out_served_priority == '0)
    else $error("nonzero fields without served task");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  a_busy_by_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_opcode) == pts_pkg::OP_POP)
    else $error("busy without pop transfer");

endmodule

bind priority_task_store pts_assert u_pts_assert (.*);

// ===== tb/pts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Watches the request and answer channels of the priority task store, keeps
// its own copy of the stored tasks, predicts the answer of every accepted
// request and compares each answer strobe field by field, in order.
// ----------------------------------------------------------------------------
module pts_checker #(
  parameter int CAPACITY = pts_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_opcode,
  input  logic [pts_pkg::ID_W-1:0]    in_task_id,
  input  logic [pts_pkg::PRI_W-1:0]   in_task_priority,
  input  logic                        out_valid,
  input  logic [pts_pkg::STAT_W-1:0]  out_status,
  input  logic [pts_pkg::ID_W-1:0]    out_served_id,
  input  logic [pts_pkg::PRI_W-1:0]   out_served_priority,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [pts_pkg::STAT_W-1:0] status;
    logic [pts_pkg::ID_W-1:0]   id;
    logic [pts_pkg::PRI_W-1:0]  pri;
  } answer_t;

  logic [pts_pkg::ID_W-1:0]  id_mem  [CAPACITY];
  logic [pts_pkg::PRI_W-1:0] pri_mem [CAPACITY];
  int                        task_count;
  answer_t                   answer_q [$];
  int                        errors;

  initial begin
    task_count = 0;
    errors     = 0;
    pending    = 0;
  end

  assign fail_count = errors;

  function automatic answer_t store_or_serve(input logic op,
                                             input logic [pts_pkg::ID_W-1:0] id,
                                             input logic [pts_pkg::PRI_W-1:0] pri);
    answer_t a;
    int      best;
    int      last;
    a = '{status: pts_pkg::STAT_PUSHED, id: '0, pri: '0};
    if (op == pts_pkg::OP_PUSH) begin
      if (task_count >= CAPACITY) begin
        a.status = pts_pkg::STAT_FULL;
      end else begin
        id_mem[task_count]  = id;
        pri_mem[task_count] = pri;
        task_count++;
      end
    end else if (task_count == 0) begin
      a.status = pts_pkg::STAT_EMPTY;
    end else begin
      last = task_count - 1;
      best = 0;
      // earliest maximum wins, unless the newest task ties it
      for (int i = 1; i <= last; i++) begin
        if (pri_mem[i] > pri_mem[best] || (pri_mem[i] == pri_mem[best] && i == last))
          best = i;
      end
      a = '{status: pts_pkg::STAT_SERVED, id: id_mem[best], pri: pri_mem[best]};
      for (int i = best; i < last; i++) begin
        id_mem[i]  = id_mem[i+1];
        pri_mem[i] = pri_mem[i+1];
      end
      task_count = last;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      task_count = 0;
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected answer: expected none, got status=%0d id=%h pri=%h",
                   $time, out_status, out_served_id, out_served_priority);
        end else begin
          want = answer_q.pop_front();
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_status);
          end
          if (out_served_id !== want.id) begin
            errors++;
            $display("%0t: served_id mismatch: expected %h, got %h",
                     $time, want.id, out_served_id);
          end
          if (out_served_priority !== want.pri) begin
            errors++;
            $display("%0t: served_priority mismatch: expected %h, got %h",
                     $time, want.pri, out_served_priority);
          end
        end
      end
      if (start && !busy)
        answer_q.push_back(store_or_serve(in_opcode, in_task_id, in_task_priority));
    end
    pending = answer_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Request stimulus for the priority task store: directed pushes and pops
// covering the empty store, a single task, ties and extreme fields, then
// random segments with varying push shares that fill and drain the store,
// under several idle patterns. The checker beside the block scores answers.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP        = pts_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS = 1050;
  localparam int LIMIT      = 1_000_000;

  logic                       clk;
  logic                       rst_n            = 1'b0;
  logic                       start            = 1'b0;
  logic                       in_opcode        = pts_pkg::OP_PUSH;
  logic [pts_pkg::ID_W-1:0]   in_task_id       = '0;
  logic [pts_pkg::PRI_W-1:0]  in_task_priority = '0;
  logic                       busy;
  logic                       out_valid;
  logic [pts_pkg::STAT_W-1:0] out_status;
  logic [pts_pkg::ID_W-1:0]   out_served_id;
  logic [pts_pkg::PRI_W-1:0]  out_served_priority;
  int                         fail_count;
  int                         pending;
  int                         idle_pct = 0;
  int unsigned                cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  priority_task_store #(.CAPACITY(CAP)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_task_id          (in_task_id),
    .in_task_priority    (in_task_priority),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_id       (out_served_id),
    .out_served_priority (out_served_priority)
  );

  pts_checker #(.CAPACITY(CAP)) u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_task_id          (in_task_id),
    .in_task_priority    (in_task_priority),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_id       (out_served_id),
    .out_served_priority (out_served_priority),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL priority_task_store");
      $finish;
    end
  end

  // Called in the time step of a rising edge; returns in the step of the
  // edge that completed the transfer.
  task automatic send(input logic op, input logic [pts_pkg::ID_W-1:0] id,
                      input logic [pts_pkg::PRI_W-1:0] pri);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_task_id       <= id;
    in_task_priority <= pri;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int sent;
    int seg_len;
    int push_pct;
    int pri_mode;
    logic [pts_pkg::PRI_W-1:0] pri;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send(pts_pkg::OP_POP,  16'h1234, 8'h55);
    send(pts_pkg::OP_PUSH, 16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'hFFFF, 8'hFF);
    send(pts_pkg::OP_PUSH, 16'hFFFF, 8'hFF);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_PUSH, 16'h0001, 8'h05);
    send(pts_pkg::OP_PUSH, 16'h0002, 8'h09);
    send(pts_pkg::OP_PUSH, 16'h0003, 8'h09);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_PUSH, 16'hAAAA, 8'h07);
    send(pts_pkg::OP_PUSH, 16'h5555, 8'h07);
    send(pts_pkg::OP_PUSH, 16'h00FF, 8'h03);
    send(pts_pkg::OP_PUSH, 16'hFF00, 8'hFF);
    send(pts_pkg::OP_PUSH, 16'h0F0F, 8'hFF);
    send(pts_pkg::OP_PUSH, 16'hF0F0, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);
    send(pts_pkg::OP_POP,  16'h0000, 8'h00);

    // hold off until the store has answered everything
    drain();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ((sent / 150) % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 78;
        2:       idle_pct = 0;
        default: idle_pct = 33;
      endcase
      case ($urandom_range(4))
        0:       push_pct = 100;
        1:       push_pct = 85;
        2:       push_pct = 55;
        3:       push_pct = 45;
        default: push_pct = 15;
      endcase
      pri_mode = $urandom_range(2);
      seg_len  = (push_pct == 100) ? 70 : $urandom_range(20, 80);
      repeat (seg_len) begin
        case (pri_mode)
          0:       pri = pts_pkg::PRI_W'($urandom_range(255));
          1:       pri = pts_pkg::PRI_W'($urandom_range(3));
          default: pri = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        send(($urandom_range(99) < push_pct) ? pts_pkg::OP_PUSH : pts_pkg::OP_POP,
             pts_pkg::ID_W'($urandom_range(16'hFFFF)), pri);
        sent++;
      end
      if ($urandom_range(5) == 0)
        drain();
    end

    drain();
    repeat (2 * CAP + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS priority_task_store");
    else
      $display("FAIL priority_task_store");
    $finish;
  end

endmodule
